// ===== design/aminv_pkg.sv =====
// ----------------------------------------------------------------------------
// aminv_pkg
// Types, constants and the arithmetic step table of the affine inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package aminv_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned ELEM_W        = 32;
  localparam int unsigned OPND_W        = ELEM_W + 1;
  localparam int unsigned PROD_W        = 2 * OPND_W;
  localparam int unsigned ACC_W         = PROD_W + 32;
  localparam int unsigned COF_W         = 64;
  localparam int unsigned MAT_N         = 12;
  localparam int unsigned QUOT_W        = ELEM_W + 1;
  localparam int unsigned NUM_STEPS     = 42;
  localparam int unsigned STEP_W        = $clog2(NUM_STEPS);
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 32;

  // operand codes: matrix words, then cofactor low words, then high words
  localparam logic [4:0] OPD_COF_LO = 5'd12;
  localparam logic [4:0] OPD_COF_HI = 5'd21;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DET_MIN = 1'b1;

  localparam logic [1:0] ROW_T = 2'd3;

  typedef logic [3:0][2:0][ELEM_W-1:0] mat_t;

  typedef struct packed {
    logic [1:0]               row;
    logic signed [ELEM_W-1:0] elem_x;
    logic signed [ELEM_W-1:0] elem_y;
    logic signed [ELEM_W-1:0] elem_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               out_row;
    logic signed [ELEM_W-1:0] res_x;
    logic signed [ELEM_W-1:0] res_y;
    logic signed [ELEM_W-1:0] res_z;
    logic                     singular;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    DST_COF = 2'd0,
    DST_DET = 2'd1,
    DST_TRN = 2'd2
  } dst_e;

  typedef struct packed {
    logic [4:0] opa;
    logic [4:0] opb;
    logic       sub;
    logic       sh32;
    logic       first;
    logic       last;
    dst_e       dst;
    logic [3:0] dst_idx;
  } uop_t;

  function automatic int nx3(input int x);
    return (x == 2) ? 0 : x + 1;
  endfunction

  function automatic logic [4:0] mel(input int r, input int c);
    return 5'(r * 3 + c);
  endfunction

  // multiply-accumulate program: nine cofactors, determinant, translation sums
  function automatic uop_t uop_rom(input logic [STEP_W-1:0] st);
    uop_t u;
    int   i, r1, r2, s1, s2, j;
    u = '0;
    u.dst = DST_COF;
    for (int r = 0; r < 3; r++) begin
      for (int s = 0; s < 3; s++) begin
        i  = r * 3 + s;
        s1 = nx3(s);
        s2 = nx3(s1);
        r1 = nx3(r);
        r2 = nx3(r1);
        if (st == STEP_W'(2 * i)) begin
          u.opa   = mel(s1, r1);
          u.opb   = mel(s2, r2);
          u.first = 1'b1;
        end
        if (st == STEP_W'(2 * i + 1)) begin
          u.opa     = mel(s2, r1);
          u.opb     = mel(s1, r2);
          u.sub     = 1'b1;
          u.last    = 1'b1;
          u.dst     = DST_COF;
          u.dst_idx = 4'(i);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int h = 0; h < 2; h++) begin
        if (st == STEP_W'(18 + 2 * k + h)) begin
          u.opa   = mel(0, k);
          u.opb   = (h == 1) ? OPD_COF_HI + 5'(k * 3) : OPD_COF_LO + 5'(k * 3);
          u.sh32  = 1'(h);
          u.first = 1'(k == 0 && h == 0);
          u.last  = 1'(k == 2 && h == 1);
          u.dst   = DST_DET;
        end
      end
    end
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 3; k++) begin
        for (int h = 0; h < 2; h++) begin
          j = 24 + 6 * s + 2 * k + h;
          if (st == STEP_W'(j)) begin
            u.opa     = mel(3, k);
            u.opb     = (h == 1) ? OPD_COF_HI + 5'(k * 3 + s) : OPD_COF_LO + 5'(k * 3 + s);
            u.sh32    = 1'(h);
            u.first   = 1'(k == 0 && h == 0);
            u.last    = 1'(k == 2 && h == 1);
            u.dst     = DST_TRN;
            u.dst_idx = 4'(s);
          end
        end
      end
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== design/aminv_front.sv =====
// ----------------------------------------------------------------------------
// aminv_front
// Row loader: keeps the matrix rows and hands a full matrix to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module aminv_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire aminv_pkg::in_item_t item_i,
  input  wire logic                full_i,
  output logic                     busy_o,
  output logic                     push_o,
  output aminv_pkg::mat_t          job_o
);
  import aminv_pkg::*;

  mat_t store_q;
  logic accept;

  assign busy_o = full_i;
  assign accept = start_i && !full_i;
  assign push_o = accept && (item_i.row == ROW_T);

  always_comb begin
    job_o       = store_q;
    job_o[ROW_T] = {item_i.elem_z, item_i.elem_y, item_i.elem_x};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
    end else if (accept) begin
      store_q[item_i.row] <= {item_i.elem_z, item_i.elem_y, item_i.elem_x};
    end
  end

endmodule

`default_nettype wire

// ===== design/aminv_fifo.sv =====
// ----------------------------------------------------------------------------
// aminv_fifo
// Short job queue between the row loader and the compute engine.
// ----------------------------------------------------------------------------
`default_nettype none

module aminv_fifo #(
  parameter int unsigned DEPTH = aminv_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire aminv_pkg::mat_t din_i,
  input  wire logic            pop_i,
  output aminv_pkg::mat_t      dout_o,
  output logic                 empty_o,
  output logic                 full_o
);
  import aminv_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mat_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/aminv_div.sv =====
// ----------------------------------------------------------------------------
// aminv_div
// Radix-2 restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
`default_nettype none

module aminv_div #(
  parameter int unsigned NUM_W = 114,
  parameter int unsigned DEN_W = 98
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0]        dmag_i,
  input  wire logic                    dneg_i,
  output logic                         done_o,
  output logic signed [31:0]           quot_o
);
  import aminv_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_CHK  = 4'b0010,
    D_RUN  = 4'b0100,
    D_DONE = 4'b1000
  } dstate_e;

  dstate_e           state_q;
  logic [NUM_W-1:0]  u_q;
  logic [DEN_W-1:0]  d_q, rem_q;
  logic [QUOT_W-1:0] lo_q, q_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              neg_q, ovf_q;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, lo_q[QUOT_W-1]};
  assign fits  = (trial >= {1'b0, d_q});

  always_comb begin
    if (!neg_q) begin
      quot_o = (ovf_q || q_q[QUOT_W-1:QUOT_W-2] != 2'b00) ? 32'sh7FFF_FFFF
                                                           : signed'(q_q[31:0]);
    end else begin
      quot_o = (ovf_q || q_q > QUOT_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                          : signed'(32'(-q_q[31:0]));
    end
  end

  assign done_o = (state_q == D_DONE);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          u_q   <= num_i[NUM_W-1] ? NUM_W'(-num_i) : num_i;
          neg_q <= num_i[NUM_W-1] ^ dneg_i;
          d_q   <= dmag_i;
        end
      end
      D_CHK: begin
        // quotient at or above 2^33 saturates whatever its sign
        ovf_q <= ({{(DEN_W + QUOT_W - NUM_W){1'b0}}, u_q} >= {d_q, {QUOT_W{1'b0}}});
        rem_q <= DEN_W'(u_q >> QUOT_W);
        lo_q  <= u_q[QUOT_W-1:0];
        q_q   <= '0;
        cnt_q <= CNT_W'(QUOT_W - 1);
      end
      D_RUN: begin
        rem_q <= fits ? DEN_W'(trial - {1'b0, d_q}) : DEN_W'(trial);
        q_q   <= {q_q[QUOT_W-2:0], fits};
        lo_q  <= {lo_q[QUOT_W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      D_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      unique case (state_q)
        D_IDLE:  if (start_i) state_q <= D_CHK;
        D_CHK:   state_q <= D_RUN;
        D_RUN:   if (cnt_q == '0) state_q <= D_DONE;
        D_DONE:  state_q <= D_IDLE;
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/aminv_back.sv =====
// ----------------------------------------------------------------------------
// aminv_back
// Compute engine: cofactors, determinant and translation by one shared
// multiply-accumulate, then nine, twelve or no divisions and four result rows.
// ----------------------------------------------------------------------------
`default_nettype none

module aminv_back #(
  parameter int unsigned FRAC_BITS = aminv_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 job_valid_i,
  input  wire aminv_pkg::mat_t      job_i,
  output logic                      job_pop_o,
  input  wire logic                 mode_i,
  input  wire logic [31:0]          det_min_i,
  output logic                      res_valid_o,
  output aminv_pkg::out_item_t      res_o
);
  import aminv_pkg::*;

  localparam int unsigned NUM_W = ACC_W + FRAC_BITS;

  typedef enum logic [7:0] {
    B_IDLE   = 8'b0000_0001,
    B_OPA    = 8'b0000_0010,
    B_MUL    = 8'b0000_0100,
    B_ACC    = 8'b0000_1000,
    B_CHK    = 8'b0001_0000,
    B_DSTART = 8'b0010_0000,
    B_DWAIT  = 8'b0100_0000,
    B_ZERO   = 8'b1000_0000
  } bstate_e;

  bstate_e                   state_q;
  mat_t                      mat_q;
  logic [MAT_N-1:0][31:0]    mat_flat;
  logic [8:0][COF_W-1:0]     cof_q;
  logic signed [ACC_W-1:0]   det_q, acc_q, acc_d, addend;
  logic signed [ACC_W-1:0]   trans_q [3];
  logic [ACC_W-1:0]          dmag_q, mag;
  logic                      dneg_q, sing_q;
  logic [STEP_W-1:0]         step_q;
  logic signed [OPND_W-1:0]  opa_q, opnd;
  logic signed [PROD_W-1:0]  prod_q;
  logic [1:0]                r_q, c_q;
  logic signed [31:0]        rx_q, ry_q;
  uop_t                      u;
  logic [4:0]                code;
  logic [3:0]                cof_idx, div_idx;
  logic [COF_W-1:0]          cof_rd;
  logic signed [NUM_W-1:0]   num, cof_ext, trn_ext;
  logic                      div_done;
  logic signed [31:0]        quot;
  out_item_t                 res_q;
  logic                      res_valid_q;

  assign mat_flat  = mat_q;
  assign u         = uop_rom(step_q);
  assign code      = (state_q == B_OPA) ? u.opa : u.opb;
  assign job_pop_o = (state_q == B_IDLE) && job_valid_i;

  // row r, column c reads cofactor (r,c); the transposed mode swaps them
  assign div_idx = mode_i ? ({2'b00, c_q} << 1) + {2'b00, c_q} + {2'b00, r_q}
                          : ({2'b00, r_q} << 1) + {2'b00, r_q} + {2'b00, c_q};

  always_comb begin
    if (state_q == B_DSTART) begin
      cof_idx = div_idx;
    end else if (code >= OPD_COF_HI) begin
      cof_idx = 4'(code - OPD_COF_HI);
    end else begin
      cof_idx = 4'(code - OPD_COF_LO);
    end
  end

  assign cof_rd = cof_q[cof_idx];

  always_comb begin
    if (code < OPD_COF_LO) begin
      opnd = OPND_W'(signed'(mat_flat[code[3:0]]));
    end else if (code < OPD_COF_HI) begin
      opnd = signed'({1'b0, cof_rd[31:0]});
    end else begin
      opnd = OPND_W'(signed'(cof_rd[COF_W-1:32]));
    end
  end

  always_comb begin
    if (u.sh32) begin
      addend = {prod_q, {(ACC_W - PROD_W){1'b0}}};
    end else begin
      addend = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    acc_d = (u.first ? '0 : acc_q) + (u.sub ? -addend : addend);
  end

  assign mag = det_q[ACC_W-1] ? ACC_W'(-det_q) : det_q;

  assign cof_ext = {{(NUM_W - COF_W){cof_rd[COF_W-1]}}, cof_rd};
  assign trn_ext = {{FRAC_BITS{trans_q[c_q][ACC_W-1]}}, trans_q[c_q]};
  assign num     = (r_q == ROW_T) ? ((-trn_ext) <<< FRAC_BITS)
                                  : (cof_ext <<< (2 * FRAC_BITS));

  aminv_div #(
    .NUM_W (NUM_W),
    .DEN_W (ACC_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == B_DSTART),
    .num_i   (num),
    .dmag_i  (dmag_q),
    .dneg_i  (dneg_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      mat_q <= job_i;
    end
    if (state_q == B_OPA) begin
      opa_q <= opnd;
    end
    if (state_q == B_MUL) begin
      prod_q <= opa_q * opnd;
    end
    if (state_q == B_ACC) begin
      acc_q <= acc_d;
      if (u.last) begin
        case (u.dst)
          DST_COF: cof_q[u.dst_idx] <= acc_d[COF_W-1:0];
          DST_DET: det_q <= acc_d;
          default: trans_q[u.dst_idx[1:0]] <= acc_d;
        endcase
      end
    end
    if (state_q == B_CHK) begin
      dmag_q <= mag;
      dneg_q <= det_q[ACC_W-1];
    end
    if (state_q == B_DWAIT && div_done) begin
      if (c_q == 2'd0) rx_q <= quot;
      if (c_q == 2'd1) ry_q <= quot;
    end
    res_q.out_row  <= r_q;
    res_q.last     <= (r_q == ROW_T);
    res_q.singular <= (state_q == B_ZERO) && sing_q;
    if (state_q == B_ZERO) begin
      res_q.res_x <= '0;
      res_q.res_y <= '0;
      res_q.res_z <= '0;
    end else begin
      res_q.res_x <= rx_q;
      res_q.res_y <= ry_q;
      res_q.res_z <= quot;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      r_q         <= '0;
      c_q         <= '0;
      sing_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            step_q  <= '0;
            state_q <= B_OPA;
          end
        end
        B_OPA: state_q <= B_MUL;
        B_MUL: state_q <= B_ACC;
        B_ACC: begin
          if (step_q == STEP_W'(NUM_STEPS - 1)) begin
            state_q <= B_CHK;
          end else begin
            step_q  <= step_q + 1'b1;
            state_q <= B_OPA;
          end
        end
        B_CHK: begin
          r_q <= '0;
          c_q <= '0;
          if (mag == '0 || mag < ACC_W'(det_min_i)) begin
            sing_q  <= 1'b1;
            state_q <= B_ZERO;
          end else begin
            sing_q  <= 1'b0;
            state_q <= B_DSTART;
          end
        end
        B_DSTART: state_q <= B_DWAIT;
        B_DWAIT: begin
          if (div_done) begin
            if (c_q != 2'd2) begin
              c_q     <= c_q + 1'b1;
              state_q <= B_DSTART;
            end else begin
              // row complete: emit it and advance
              res_valid_q <= 1'b1;
              c_q         <= '0;
              if (r_q == ROW_T) begin
                state_q <= B_IDLE;
              end else begin
                r_q     <= r_q + 1'b1;
                state_q <= (r_q == 2'd2 && mode_i) ? B_ZERO : B_DSTART;
              end
            end
          end
        end
        B_ZERO: begin
          res_valid_q <= 1'b1;
          if (r_q == ROW_T) begin
            state_q <= B_IDLE;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/affine_matrix_inverse.sv =====
// ----------------------------------------------------------------------------
// affine_matrix_inverse
// Affine 3x4 matrix inverse (adjugate method) in signed fixed point.
// ----------------------------------------------------------------------------
// Rows X, Y and Z are taken one per cycle while busy is low; row T starts a
// computation and queues the whole matrix, so busy only rises while the job
// queue is full. One matrix takes 42 multiply-accumulate steps on the single
// 33x33 multiplier, then 12 (or 9) divisions on the one-bit-per-cycle
// divider. A singular matrix finishes after the multiply phase. The four
// result rows come out on res_valid_o one cycle each and cannot be held
// off.
`default_nettype none

module affine_matrix_inverse #(
  parameter int unsigned FRAC_BITS   = aminv_pkg::FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = aminv_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire aminv_pkg::in_item_t                item_i,
  output logic                                    res_valid_o,
  output aminv_pkg::out_item_t                    res_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [aminv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [aminv_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import aminv_pkg::*;

  logic        mode_q;
  logic [31:0] det_min_q;
  logic        push, pop, empty, full;
  mat_t        job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      det_min_q <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:    mode_q    <= cfg_wdata_i[0];
        REG_DET_MIN: det_min_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  aminv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (item_i),
    .full_i  (full),
    .busy_o  (busy),
    .push_o  (push),
    .job_o   (job_in)
  );

  aminv_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (job_in),
    .pop_i   (pop),
    .dout_o  (job_out),
    .empty_o (empty),
    .full_o  (full)
  );

  aminv_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!empty),
    .job_i       (job_out),
    .job_pop_o   (pop),
    .mode_i      (mode_q),
    .det_min_i   (det_min_q),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full || pop)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("job queue underflow");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.singular |->
      res_o.res_x == '0 && res_o.res_y == '0 && res_o.res_z == '0)
    else $error("singular row carries nonzero elements");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("result row follows the last row at once");

endmodule

`default_nettype wire

// ===== sim/affine_matrix_inverse_tb.sv =====
// ----------------------------------------------------------------------------
// affine_matrix_inverse_tb
// Checks the affine 3x4 matrix inverse against an exact adjugate predictor.
// A directed table covers reset state, saturation, singular matrices and
// both modes; random matrices under several register settings follow, with
// sender gaps. Every result row is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_matrix_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aminv_pkg::*;

  localparam logic [31:0] ONE     = 32'h0001_0000;
  localparam int          WD_MAX  = 20000;

  typedef enum logic {D_WORD, D_CFG} dkind_e;

  typedef struct {
    dkind_e      kind;
    in_item_t    w;
    bit          typed;
    bit          t_sing;
    logic [31:0] t_diag, t_tx, t_ty, t_tz;
    logic        c_mode;
    logic [31:0] c_dmin;
  } dir_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      res_valid_o;
  out_item_t res_o;
  logic      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // predictor state
  logic signed [31:0] mat_q[4][3];
  logic               mode_q;
  logic [31:0]        dmin_q;
  out_item_t          inv_rows_q[$];

  int n_err, n_words, n_mats, n_sing, n_rows, wd;
  bit quiet;
  dir_t dir_q[$];

  affine_matrix_inverse i_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] div_sat(logic signed [127:0] n, logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    if (q > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (q < -128'sh8000_0000) return 32'h8000_0000;
    return q[31:0];
  endfunction

  // exact adjugate inverse of the stored matrix, four rows
  function automatic void invert_matrix();
    longint              cof[3][3];
    longint              p, q;
    logic signed [127:0] det, mag, a, b, n;
    logic [31:0]         res[4][3];
    bit                  sing;
    int                  s1, s2, r1, r2;
    out_item_t           o;
    for (int r = 0; r < 3; r++)
      for (int s = 0; s < 3; s++) begin
        s1 = (s + 1) % 3; s2 = (s + 2) % 3; r1 = (r + 1) % 3; r2 = (r + 2) % 3;
        p = longint'(mat_q[s1][r1]) * longint'(mat_q[s2][r2]);
        q = longint'(mat_q[s2][r1]) * longint'(mat_q[s1][r2]);
        cof[r][s] = p - q;
      end
    det = '0;
    for (int k = 0; k < 3; k++) begin
      a = mat_q[0][k];
      b = cof[k][0];
      det = det + a * b;
    end
    mag = (det < 0) ? -det : det;
    sing = (det == 0) || (mag < {96'b0, dmin_q});
    for (int r = 0; r < 4; r++)
      for (int s = 0; s < 3; s++) res[r][s] = '0;
    if (!sing) begin
      for (int r = 0; r < 3; r++)
        for (int s = 0; s < 3; s++) begin
          b = mode_q ? cof[s][r] : cof[r][s];
          res[r][s] = div_sat(b <<< 32, det);
        end
      if (!mode_q)
        for (int s = 0; s < 3; s++) begin
          n = '0;
          for (int k = 0; k < 3; k++) begin
            a = mat_q[3][k];
            b = cof[k][s];
            n = n + a * b;
          end
          res[3][s] = div_sat((-n) <<< 16, det);
        end
    end
    n_mats++;
    if (sing) n_sing++;
    for (int r = 0; r < 4; r++) begin
      o.out_row = 2'(r);
      o.res_x = res[r][0]; o.res_y = res[r][1]; o.res_z = res[r][2];
      o.singular = sing;
      o.last = (r == 3);
      inv_rows_q.push_back(o);
    end
  endfunction

  // hold the word until accepted; update the predictor just before the edge
  task automatic send_word(input in_item_t w);
    start <= 1'b1;
    item_i <= w;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    mat_q[w.row][0] = w.elem_x;
    mat_q[w.row][1] = w.elem_y;
    mat_q[w.row][2] = w.elem_z;
    n_words++;
    if (w.row == ROW_T) invert_matrix();
    @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (inv_rows_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_cfg(input logic m, input logic [31:0] dm);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_MODE; cfg_wdata_i <= 32'(m);
    @(posedge clk_i);
    cfg_idx_i <= REG_DET_MIN; cfg_wdata_i <= dm;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
    dmin_q = dm;
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      2: return $urandom_range(0, 255);
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic in_item_t rnd_word(input logic [1:0] r);
    in_item_t w;
    w.row = r;
    w.elem_x = rnd_elem(); w.elem_y = rnd_elem(); w.elem_z = rnd_elem();
    return w;
  endfunction

  function automatic dir_t row_w(logic [1:0] r, logic [31:0] x, y, z);
    dir_t d;
    d = '{kind: D_WORD, default: '0};
    d.w = '{row: r, elem_x: x, elem_y: y, elem_z: z};
    return d;
  endfunction

  function automatic dir_t trow_w(logic [31:0] x, y, z, bit sg,
                                  logic [31:0] dg, tx, ty, tz);
    dir_t d;
    d = row_w(ROW_T, x, y, z);
    d.typed = 1'b1; d.t_sing = sg; d.t_diag = dg;
    d.t_tx = tx; d.t_ty = ty; d.t_tz = tz;
    return d;
  endfunction

  function automatic dir_t cfg_w(logic m, logic [31:0] dm);
    dir_t d;
    d = '{kind: D_CFG, default: '0};
    d.c_mode = m; d.c_dmin = dm;
    return d;
  endfunction

  function automatic void diag_rows(logic [31:0] v);
    dir_q.push_back(row_w(2'd0, v, 0, 0));
    dir_q.push_back(row_w(2'd1, 0, v, 0));
    dir_q.push_back(row_w(2'd2, 0, 0, v));
  endfunction

  // result checker
  always @(negedge clk_i) begin
    out_item_t e;
    if (rst_ni && res_valid_o) begin
      n_rows++;
      if (inv_rows_q.size() == 0) begin
        $display("%0t: unexpected row, actual %p", $time, res_o);
        n_err++;
      end else begin
        e = inv_rows_q.pop_front();
        if (res_o.out_row !== e.out_row || res_o.res_x !== e.res_x ||
            res_o.res_y !== e.res_y || res_o.res_z !== e.res_z ||
            res_o.singular !== e.singular || res_o.last !== e.last) begin
          $display("%0t: mismatch, expected %p actual %p", $time, e, res_o);
          n_err++;
        end
      end
    end
  end

  // watchdog: cycles with no word moved in either direction
  always @(negedge clk_i) begin
    if (res_valid_o || (start && !busy)) wd <= 0;
    else wd <= wd + 1;
    if (wd >= WD_MAX) begin
      $display("affine_matrix_inverse_tb: errors");
      $finish;
    end
  end

  initial begin
    dir_t       d;
    out_item_t  o;
    logic [1:0] r;
    logic [31:0] dm;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) mat_q[i][k] = '0;
    mode_q = 1'b0; dmin_q = 32'd1;
    n_err = 0; n_words = 0; n_mats = 0; n_sing = 0; n_rows = 0; wd = 0;
    quiet = 1'b0;

    // zero store after reset is singular
    dir_q.push_back(trow_w(ONE, 2 * ONE, 3 * ONE, 1, 0, 0, 0, 0));
    // identity with extreme translation: saturates on negation of the minimum
    diag_rows(ONE);
    dir_q.push_back(trow_w(32'h7FFF_FFFF, 32'h8000_0000, 5 * ONE, 0, ONE,
                           32'h8000_0001, 32'h7FFF_FFFF, -(5 * ONE)));
    // tiny diagonals overflow the inverse both ways
    diag_rows(32'd1);
    dir_q.push_back(trow_w(0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
    diag_rows(32'hFFFF_FFFF);
    dir_q.push_back(trow_w(0, 0, 0, 0, 32'h8000_0000, 0, 0, 0));
    // threshold at its maximum flags a small determinant
    dir_q.push_back(cfg_w(1'b0, 32'hFFFF_FFFF));
    diag_rows(32'h100);
    dir_q.push_back(trow_w(ONE, ONE, ONE, 1, 0, 0, 0, 0));
    // zero determinant stays singular with no threshold
    dir_q.push_back(cfg_w(1'b0, 32'h0));
    dir_q.push_back(row_w(2'd0, 0, 0, 0));
    dir_q.push_back(trow_w(ONE, ONE, ONE, 1, 0, 0, 0, 0));
    // transpose mode drops the translation
    dir_q.push_back(cfg_w(1'b1, 32'd1));
    diag_rows(ONE);
    dir_q.push_back(trow_w(9 * ONE, 9 * ONE, 9 * ONE, 0, ONE, 0, 0, 0));
    dir_q.push_back(row_w(2'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    dir_q.push_back(row_w(2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    dir_q.push_back(row_w(ROW_T, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    dir_q.push_back(cfg_w(1'b0, 32'd1));
    dir_q.push_back(row_w(ROW_T, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) begin
      d = dir_q[i];
      if (d.kind == D_CFG) begin
        drain();
        set_cfg(d.c_mode, d.c_dmin);
      end else begin
        maybe_gap();
        send_word(d.w);
        if (d.typed) begin
          repeat (4) void'(inv_rows_q.pop_back());
          for (int k = 0; k < 4; k++) begin
            o.out_row = 2'(k);
            o.singular = d.t_sing;
            o.last = (k == 3);
            if (k == 3) begin
              o.res_x = d.t_tx; o.res_y = d.t_ty; o.res_z = d.t_tz;
            end else begin
              o.res_x = (k == 0) ? d.t_diag : 32'h0;
              o.res_y = (k == 1) ? d.t_diag : 32'h0;
              o.res_z = (k == 2) ? d.t_diag : 32'h0;
            end
            inv_rows_q.push_back(o);
          end
        end
      end
    end

    // random matrices, one register setting per phase
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: dm = 32'd1;
        1: dm = 32'd0;
        2: dm = $urandom;
        default: dm = 32'hFFFF_FFFF;
      endcase
      set_cfg(ph[0], dm);
      quiet = (ph == 3);
      for (int n = 0; n < 26; ) begin
        if ($urandom_range(0, 6) != 0) begin
          for (int k = 0; k < 4; k++) begin
            maybe_gap();
            send_word(rnd_word(2'(k)));
          end
          n += 4;
        end else begin
          r = 2'($urandom_range(0, 3));
          maybe_gap();
          send_word(rnd_word(r));
          n++;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d words, %0d matrices (%0d singular), checked %0d rows,",
             n_words, n_mats, n_sing, n_rows);
    $display("both modes, thresholds 0 to max, saturation and sender gaps.");
    if (n_err == 0 && inv_rows_q.size() == 0) begin
      $display("affine_matrix_inverse_tb: clean");
    end else begin
      $display("affine_matrix_inverse_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/aminv_pkg.sv
design/aminv_front.sv
design/aminv_fifo.sv
design/aminv_div.sv
design/aminv_back.sv
design/affine_matrix_inverse.sv
sim/affine_matrix_inverse_tb.sv
